### sv/adjacency_record_edge_parser_defines.svh
// ----------------------------------------------------------------------------
// adjacency record edge parser: assertion macros
// concurrent check wrappers, removed when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ADJACENCY_RECORD_EDGE_PARSER_DEFINES_SVH
`define ADJACENCY_RECORD_EDGE_PARSER_DEFINES_SVH

`ifndef SYNTH
// plain property under clock and reset
`define AREP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// same-cycle implication
`define AREP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define AREP_ASSERT(lbl, clk, rst_n, prop, msg)
`define AREP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### sv/arep_pkg.sv
// ----------------------------------------------------------------------------
// arep_pkg
// shared constants and types of the adjacency record edge parser
// ----------------------------------------------------------------------------
package arep_pkg;

  // record field geometry defaults
  localparam int unsigned FIELD_BYTES = 6;
  localparam int unsigned VERTEX_BITS = 32;

  // width of the vertex fields on the edge channel
  localparam int unsigned OUT_W = 32;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIENT_LARGER_FIRST = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_SELF_LOOPS     = 1'b1;

  typedef struct packed {
    logic [OUT_W-1:0] src_vertex;
    logic [OUT_W-1:0] dst_vertex;
  } edge_t;

endpackage

### sv/arep_byte_if.sv
// ----------------------------------------------------------------------------
// arep_byte_if
// byte stream channel: one raw byte and its file start flag per transfer
// ----------------------------------------------------------------------------
interface arep_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

### sv/arep_edge_if.sv
// ----------------------------------------------------------------------------
// arep_edge_if
// edge channel: one source / destination vertex pair per transfer
// ----------------------------------------------------------------------------
interface arep_edge_if;
  import arep_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] src_vertex;
  logic [OUT_W-1:0] dst_vertex;

  modport source (output valid, output src_vertex, output dst_vertex, input ready);
  modport sink   (input valid, input src_vertex, input dst_vertex, output ready);
endinterface

### sv/arep_out_buf.sv
// ----------------------------------------------------------------------------
// arep_out_buf
// two-entry edge buffer: registered output stage plus skid stage
// ----------------------------------------------------------------------------
module arep_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  arep_pkg::edge_t push_data_i,
  output logic            space_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output arep_pkg::edge_t out_data_o
);
  import arep_pkg::*;

  logic  out_valid_q, out_valid_d;
  logic  skid_valid_q, skid_valid_d;
  edge_t out_data_q, out_data_d;
  edge_t skid_data_q, skid_data_d;
  logic  pop;

  assign pop     = out_valid_q && out_ready_i;
  assign space_o = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (push_i) begin
      // a push only comes while the skid stage is empty
      if (!out_valid_q || pop) begin
        out_valid_d = 1'b1;
        out_data_d  = push_data_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_data_d  = push_data_i;
      end
    end else if (pop) begin
      if (skid_valid_q) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### sv/adjacency_record_edge_parser.sv
// ----------------------------------------------------------------------------
// adjacency_record_edge_parser
// turns a byte stream of adjacency records into a stream of edges
// ----------------------------------------------------------------------------
// Takes one byte per transfer on byte_i and sustains one byte per clock cycle
// unless stalled. A record is a source vertex, a neighbour count and then that
// many destination vertices, each FIELD_BYTES bytes, big-endian. Every
// completed destination field gives one edge on edge_o, at most one edge per
// byte; the byte passes the input register, then is parsed into the output
// stage. A two-entry output buffer lets bytes keep flowing while an edge
// waits; byte_i only stalls once both buffer entries are held. The per-byte
// path is the FIELD_BYTES*8-bit neighbour count decrement and zero test.
// Vertices keep their low VERTEX_BITS bits (at most 32). A byte with
// file_start set restarts parsing at the source field and discards any
// partial record. Configuration: register 0 orient_larger_first, register 1
// drop_self_loops, both reset to 1; write them only while the block is idle.
// ----------------------------------------------------------------------------
`include "adjacency_record_edge_parser_defines.svh"

module adjacency_record_edge_parser #(
  parameter int unsigned FIELD_BYTES = arep_pkg::FIELD_BYTES,
  parameter int unsigned VERTEX_BITS = arep_pkg::VERTEX_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  arep_byte_if.sink                      byte_i,
  arep_edge_if.source                    edge_o,
  input  logic                           cfg_we_i,
  input  logic [arep_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [arep_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import arep_pkg::*;

  // field and vertex widths
  localparam int unsigned FieldW = FIELD_BYTES * 8;
  localparam int unsigned CutA   = (VERTEX_BITS < OUT_W) ? VERTEX_BITS : OUT_W;
  localparam int unsigned CutW   = (CutA < FieldW) ? CutA : FieldW;
  localparam int unsigned PosW   = (FIELD_BYTES > 1) ? $clog2(FIELD_BYTES) : 1;

  typedef enum logic [1:0] {
    PH_SRC = 2'd0,
    PH_CNT = 2'd1,
    PH_DST = 2'd2
  } phase_e;

  // configuration registers
  logic orient_q;
  logic drop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orient_q <= 1'b1;
      drop_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ORIENT_LARGER_FIRST: orient_q <= cfg_wdata_i[0];
        CFG_DROP_SELF_LOOPS:     drop_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_fs_q;
  logic       fire;
  logic       space;

  // the parse stage moves on whenever the output buffer has a free entry
  assign fire         = in_valid_q && space;
  assign byte_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_i.ready) begin
      in_valid_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.data_byte;
      in_fs_q   <= byte_i.file_start;
    end
  end

  // parser state
  phase_e            phase_q, phase_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [FieldW-1:0] acc_q, acc_d;
  logic [CutW-1:0]   src_q, src_d;
  logic [FieldW-1:0] nl_q, nl_d;

  // state as seen by this byte, after a possible file restart
  phase_e            phase_eff;
  logic [PosW-1:0]   pos_eff;
  logic [FieldW-1:0] acc_eff;
  logic [FieldW-1:0] nl_eff;
  logic [FieldW-1:0] value;
  logic [CutW-1:0]   dst_cut;
  logic [FieldW-1:0] nl_dec;
  logic              last_byte;
  logic              emit;
  logic [OUT_W-1:0]  s_ext;
  logic [OUT_W-1:0]  d_ext;
  edge_t             edge_res;

  assign phase_eff = in_fs_q ? PH_SRC : phase_q;
  assign pos_eff   = in_fs_q ? '0 : pos_q;
  assign acc_eff   = in_fs_q ? '0 : acc_q;
  assign nl_eff    = in_fs_q ? '0 : nl_q;

  // big-endian gather: shift in the new byte at the bottom
  assign value     = FieldW'({acc_eff, in_byte_q});
  assign last_byte = (pos_eff == PosW'(FIELD_BYTES - 1));
  assign dst_cut   = value[CutW-1:0];
  assign nl_dec    = nl_eff - FieldW'(1);

  assign s_ext = OUT_W'(src_q);
  assign d_ext = OUT_W'(dst_cut);

  always_comb begin
    phase_d = phase_eff;
    pos_d   = pos_eff + PosW'(1);
    acc_d   = value;
    src_d   = src_q;
    nl_d    = nl_eff;
    emit    = 1'b0;
    if (last_byte) begin
      pos_d = '0;
      acc_d = '0;
      case (phase_eff)
        PH_CNT: begin
          // an empty neighbour list closes the record at once
          nl_d    = value;
          phase_d = (value != '0) ? PH_DST : PH_SRC;
        end
        PH_DST: begin
          nl_d    = nl_dec;
          phase_d = (nl_dec == '0) ? PH_SRC : PH_DST;
          emit    = !(drop_q && (src_q == dst_cut));
        end
        default: begin
          // source field, and the unused code acting as one
          src_d   = value[CutW-1:0];
          phase_d = PH_CNT;
        end
      endcase
    end
  end

  // optional orientation, larger vertex first
  always_comb begin
    if (orient_q && (s_ext < d_ext)) begin
      edge_res.src_vertex = d_ext;
      edge_res.dst_vertex = s_ext;
    end else begin
      edge_res.src_vertex = s_ext;
      edge_res.dst_vertex = d_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SRC;
      pos_q   <= '0;
      acc_q   <= '0;
      src_q   <= '0;
      nl_q    <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      acc_q   <= acc_d;
      src_q   <= src_d;
      nl_q    <= nl_d;
    end
  end

  // output stage and skid entry
  edge_t out_data;
  logic  push;

  assign push = fire && emit;

  arep_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (edge_res),
    .space_o     (space),
    .out_valid_o (edge_o.valid),
    .out_ready_i (edge_o.ready),
    .out_data_o  (out_data)
  );

  assign edge_o.src_vertex = out_data.src_vertex;
  assign edge_o.dst_vertex = out_data.dst_vertex;

  // checks

  // the skid entry is only ever held behind a presented edge
  `AREP_ASSERT_IMPL(a_skid_behind_out, clk_i, rst_ni, !space, edge_o.valid, "skid held without output")
  // while destinations are expected the count is never zero
  `AREP_ASSERT_IMPL(a_dst_count_live, clk_i, rst_ni, phase_q == PH_DST, nl_q != '0, "zero count in dst phase")
  // byte position stays inside a field
  `AREP_ASSERT(a_pos_range, clk_i, rst_ni, pos_q <= PosW'(FIELD_BYTES - 1), "byte position out of range")
  // with self loop removal on, no edge with equal endpoints is pushed
  `AREP_ASSERT_IMPL(a_no_self_loop, clk_i, rst_ni, push && drop_q, edge_res.src_vertex != edge_res.dst_vertex, "self loop pushed")

endmodule
